>>> src/otq_pkg.sv
// Shared types, constants and codes of the ordered timer queue.
// No dependencies.
`default_nettype none
package otq_pkg;
  localparam int unsigned Slots        = 16;
  localparam int unsigned SlotBits     = $clog2(Slots);
  localparam int unsigned TimeBits     = 48;
  localparam int unsigned IdBits       = 32;
  localparam int unsigned WaitBits     = 31;
  localparam int unsigned CntBits      = 5;
  localparam int unsigned MaxDrain     = 16;
  localparam int unsigned DrainIdxBits = $clog2(MaxDrain);

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [IdBits-1:0]   id_t;
  typedef logic [SlotBits-1:0] slot_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_EXPIRE = 2'd2,
    ACT_POLL   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_EXPIRED   = 3'd1,
    ST_NOTHING   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  localparam logic CFG_MAX_DRAIN    = 1'b0;
  localparam logic CFG_DEFAULT_WAIT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,      // walk all slots once
    S_ADD_OUT,
    S_CANCEL_OUT,
    S_POLL_OUT,
    S_NONE_OUT,  // expire with nothing due
    S_EXP_PICK,  // earliest due found: take it
    S_RELOAD,    // walk taken list, reload periodic timers
    S_COUNT,     // count timers still due
    S_EMIT,      // emit taken timers
    S_WAIT_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       load;       // latch request
    logic       scan_clr;   // start a slot walk
    logic       scan_step;  // examine slot at scan index
    logic       due_only;
    logic       do_add;
    logic       do_cancel;
    logic       take;       // invalidate best, push on taken list
    logic       reload_step;
    logic       count_step;
    logic       emit_step;
    logic       out_load;
    status_e    out_status;
    logic       out_last;
    logic [1:0] out_sel;    // 0 zero id, 1 add id, 2 target, 3 taken id
    logic       out_wait;
    logic       out_exp;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic    scan_end;
    logic    found;
    logic    list_end;
    logic    drain_full;  // the next take reaches the drain limit
    logic    none_taken;
    action_e action;
  } stat_t;
endpackage
`default_nettype wire

>>> src/otq_datapath.sv
// Datapath: slot registers, request latch, scan and result registers.
// Depends on otq_pkg.
`default_nettype none
module otq_datapath import otq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctrl_t               ctrl_i,
  output stat_t                    stat_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [TimeBits-1:0] now_i,
  input  wire logic [TimeBits-1:0] deadline_i,
  input  wire logic [TimeBits-1:0] period_i,
  input  wire logic [IdBits-1:0]   target_id_i,
  input  wire logic [CntBits-1:0]  max_drain_i,
  input  wire logic [WaitBits-1:0] default_wait_i,
  output logic [IdBits-1:0]        timer_id_o,
  output logic [2:0]               status_o,
  output logic                     is_last_o,
  output logic [WaitBits-1:0]      wait_ticks_o,
  output logic [CntBits-1:0]       ready_left_o,
  output logic [TimeBits-1:0]      lateness_o
);
  logic [Slots-1:0] valid_q;
  id_t   id_q  [Slots];
  time_t dl_q  [Slots];
  time_t per_q [Slots];
  id_t   next_id_q;

  action_e act_q;
  time_t now_q, dlin_q, perin_q;
  id_t   tgt_q;

  logic [SlotBits:0] idx_q;
  slot_t best_q;
  logic  found_q;
  slot_t taken_q [MaxDrain];
  logic [CntBits-1:0] ntaken_q, lptr_q, cap;
  logic [CntBits-1:0] ready_q;
  time_t late_q;

  slot_t si, tk;
  logic  cand, better, list_end;
  assign si = idx_q[SlotBits-1:0];
  assign tk = taken_q[lptr_q[DrainIdxBits-1:0]];
  assign cap = (max_drain_i == '0) ? CntBits'(1) :
               (max_drain_i > CntBits'(MaxDrain)) ? CntBits'(MaxDrain) : max_drain_i;

  always_comb begin
    cand = valid_q[si];
    if (ctrl_i.due_only && dl_q[si] > now_q) cand = 1'b0;
    if (act_q == ACT_ADD) cand = !valid_q[si] && !found_q;
    if (act_q == ACT_CANCEL) cand = valid_q[si] && id_q[si] == tgt_q && tgt_q != '0
                                    && !found_q;
    better = !found_q || dl_q[si] < dl_q[best_q] ||
             (dl_q[si] == dl_q[best_q] && id_q[si] < id_q[best_q]);
    if (act_q == ACT_ADD || act_q == ACT_CANCEL) better = 1'b1;
  end

  assign list_end          = (lptr_q + CntBits'(1) >= ntaken_q);
  assign stat_o.scan_end   = (idx_q == (SlotBits+1)'(Slots - 1));
  assign stat_o.found      = found_q;
  assign stat_o.list_end   = list_end;
  assign stat_o.drain_full = (ntaken_q + CntBits'(1) >= cap);
  assign stat_o.none_taken = (ntaken_q == '0);
  assign stat_o.action     = act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      next_id_q <= IdBits'(1);
      found_q   <= 1'b0;
      idx_q     <= '0;
      ntaken_q  <= '0;
      lptr_q    <= '0;
      ready_q   <= '0;
    end else begin
      if (ctrl_i.load) begin
        ntaken_q <= '0;
        ready_q  <= '0;
        lptr_q   <= '0;
      end
      if (ctrl_i.scan_clr) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (ctrl_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
        if (cand && better) begin
          found_q <= 1'b1;
          best_q  <= si;
        end
      end
      if (ctrl_i.do_add) begin
        valid_q[best_q] <= 1'b1;
        next_id_q <= (next_id_q == '1) ? IdBits'(1) : next_id_q + 1'b1;
      end
      if (ctrl_i.do_cancel) valid_q[best_q] <= 1'b0;
      if (ctrl_i.take) begin
        valid_q[best_q] <= 1'b0;
        taken_q[ntaken_q[DrainIdxBits-1:0]] <= best_q;
        ntaken_q <= ntaken_q + 1'b1;
        if (ntaken_q == '0) late_q <= now_q - dl_q[best_q];
      end
      // rewind the list pointer on the last entry so emission starts at the head
      if (ctrl_i.reload_step) begin
        if (per_q[tk] != '0) valid_q[tk] <= 1'b1;
        lptr_q <= list_end ? '0 : lptr_q + 1'b1;
      end
      if (ctrl_i.count_step) begin
        idx_q <= idx_q + 1'b1;
        if (valid_q[si] && dl_q[si] <= now_q && ready_q != '1) ready_q <= ready_q + 1'b1;
      end
      if (ctrl_i.emit_step) lptr_q <= lptr_q + 1'b1;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      act_q   <= action_e'(action_i);
      now_q   <= now_i;
      dlin_q  <= deadline_i;
      perin_q <= period_i;
      tgt_q   <= target_id_i;
    end
    if (ctrl_i.do_add) begin
      id_q[best_q]  <= next_id_q;
      dl_q[best_q]  <= dlin_q;
      per_q[best_q] <= perin_q;
    end
    if (ctrl_i.reload_step && per_q[tk] != '0)
      dl_q[tk] <= now_q + per_q[tk];
  end

  // result register
  time_t diff;
  logic [WaitBits-1:0] wsel;
  assign diff = dl_q[best_q] - now_q;
  always_comb begin
    wsel = default_wait_i;
    if (found_q) begin
      if (dl_q[best_q] <= now_q) wsel = '0;
      else if (diff < TimeBits'(default_wait_i)) wsel = diff[WaitBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      status_o  <= ctrl_i.out_status;
      is_last_o <= ctrl_i.out_last;
      case (ctrl_i.out_sel)
        2'd1:    timer_id_o <= next_id_q;
        2'd2:    timer_id_o <= tgt_q;
        2'd3:    timer_id_o <= id_q[tk];
        default: timer_id_o <= '0;
      endcase
      wait_ticks_o <= ctrl_i.out_wait ? wsel : '0;
      ready_left_o <= ctrl_i.out_exp ? ready_q : '0;
      lateness_o   <= ctrl_i.out_exp ? late_q : '0;
    end
  end
endmodule
`default_nettype wire

>>> src/otq_ctrl.sv
// Controller state machine sequencing slot walks and result transfers.
// Depends on otq_pkg.
`default_nettype none
module otq_ctrl import otq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);
  state_e state_q, state_d;
  logic   ov_q, ov_d, acc, out_free;

  assign acc         = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_free    = !ov_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (acc) state_d = S_SCAN;
      S_SCAN: begin
        if (stat_i.scan_end) begin
          unique case (stat_i.action)
            ACT_ADD:    state_d = S_ADD_OUT;
            ACT_CANCEL: state_d = S_CANCEL_OUT;
            ACT_POLL:   state_d = S_POLL_OUT;
            default:    state_d = S_EXP_PICK;
          endcase
        end
      end
      S_ADD_OUT, S_CANCEL_OUT, S_POLL_OUT, S_NONE_OUT:
        if (out_free) state_d = S_WAIT_OUT;
      S_EXP_PICK: begin
        if (!stat_i.found) state_d = stat_i.none_taken ? S_NONE_OUT : S_RELOAD;
        else if (stat_i.drain_full) state_d = S_RELOAD;
        else state_d = S_SCAN;
      end
      S_RELOAD: if (stat_i.list_end) state_d = S_COUNT;
      S_COUNT:  if (stat_i.scan_end) state_d = S_EMIT;
      S_EMIT:   if (out_free && stat_i.list_end) state_d = S_WAIT_OUT;
      S_WAIT_OUT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.out_status = ST_DONE;
    ov_d = ov_q && out_stall_i;
    ctrl_o.load     = acc;
    ctrl_o.scan_clr = acc;
    ctrl_o.due_only = (stat_i.action == ACT_EXPIRE);
    unique case (state_q)
      S_SCAN: ctrl_o.scan_step = 1'b1;
      S_ADD_OUT: if (out_free) begin
        ctrl_o.out_load = 1'b1; ctrl_o.out_last = 1'b1; ov_d = 1'b1;
        if (stat_i.found) begin
          ctrl_o.do_add = 1'b1; ctrl_o.out_sel = 2'd1;
        end else ctrl_o.out_status = ST_FULL;
      end
      S_CANCEL_OUT: if (out_free) begin
        ctrl_o.out_load = 1'b1; ctrl_o.out_last = 1'b1; ov_d = 1'b1;
        ctrl_o.out_sel = 2'd2;
        if (stat_i.found) ctrl_o.do_cancel = 1'b1;
        else ctrl_o.out_status = ST_NOT_FOUND;
      end
      S_POLL_OUT: if (out_free) begin
        ctrl_o.out_load = 1'b1; ctrl_o.out_last = 1'b1; ov_d = 1'b1;
        ctrl_o.out_wait = 1'b1;
      end
      S_NONE_OUT: if (out_free) begin
        ctrl_o.out_load = 1'b1; ctrl_o.out_last = 1'b1; ov_d = 1'b1;
        ctrl_o.out_status = ST_NOTHING;
      end
      S_EXP_PICK: begin
        if (stat_i.found) ctrl_o.take = 1'b1;
        ctrl_o.scan_clr = 1'b1;
      end
      S_RELOAD: ctrl_o.reload_step = 1'b1;
      S_COUNT:  ctrl_o.count_step = 1'b1;
      S_EMIT: if (out_free) begin
        ctrl_o.out_load = 1'b1; ov_d = 1'b1; ctrl_o.out_exp = 1'b1;
        ctrl_o.out_last = stat_i.list_end;
        ctrl_o.out_status = ST_EXPIRED; ctrl_o.out_sel = 2'd3;
        ctrl_o.emit_step = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end
endmodule
`default_nettype wire

>>> src/ordered_timer_queue.sv
// Ordered timer queue: top level joining controller and datapath.
// Depends on otq_pkg, otq_ctrl, otq_datapath.
// One request is taken at a time. Add, cancel and poll walk the sixteen slots
// once, one slot a cycle, and then load their result. Expire walks the slots
// once per drained timer, plus once more that finds nothing unless the drain
// limit is reached. It then walks the taken list, reloading periodic timers,
// walks the slots once more to count what is still due, and emits one result
// per cycle while the output is not stalled. Expire with nothing due gives a
// single result. Results sit in an output register; output stalls hold up the
// controller.
`default_nettype none
module ordered_timer_queue import otq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [WaitBits-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [TimeBits-1:0] now_i,
  input  wire logic [TimeBits-1:0] deadline_i,
  input  wire logic [TimeBits-1:0] period_i,
  input  wire logic [IdBits-1:0]   target_id_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [IdBits-1:0]        timer_id_o,
  output logic [2:0]               status_o,
  output logic                     is_last_o,
  output logic [WaitBits-1:0]      wait_ticks_o,
  output logic [CntBits-1:0]       ready_left_o,
  output logic [TimeBits-1:0]      lateness_o
);
  ctrl_t ctrl;
  stat_t stat;
  logic [CntBits-1:0]  max_drain_q;
  logic [WaitBits-1:0] default_wait_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_drain_q    <= CntBits'(16);
      default_wait_q <= WaitBits'(1000);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MAX_DRAIN) max_drain_q <= cfg_data_i[CntBits-1:0];
      else default_wait_q <= cfg_data_i;
    end
  end

  otq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_valid_o, .out_stall_i, .stat_i(stat), .ctrl_o(ctrl)
  );

  otq_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .action_i, .now_i, .deadline_i,
    .period_i, .target_id_i, .max_drain_i(max_drain_q), .default_wait_i(default_wait_q),
    .timer_id_o, .status_o, .is_last_o, .wait_ticks_o, .ready_left_o, .lateness_o
  );
endmodule
`default_nettype wire

>>> src/otq_checker.sv
// Port-level checks on the ordered timer queue, bound to the top level.
// Depends on otq_pkg.
`default_nettype none
module otq_checker import otq_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] status_o,
  input wire logic       is_last_o
);
  // one request at a time: accept blocks further input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("input not held off");
  // a result offered while stalled stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  // non-expired results always end their request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_EXPIRED |-> is_last_o) else $error("missing last");
endmodule

bind ordered_timer_queue otq_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .is_last_o
);
`default_nettype wire
